// ===== rtl/hsv_to_rgb_converter_top_defines.svh =====
// assertion macros for the hsv to rgb converter checker
`ifndef HSV_TO_RGB_CONVERTER_TOP_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_TOP_DEFINES_SVH

// checked only while out of reset
`define HSV_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define HSV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/hsv_pkg.sv =====
// shared constants, sector codes and pipeline payload types
package hsv_pkg;

  localparam int FRAC_BITS = 12;
  localparam int VAL_W     = FRAC_BITS + 1;
  localparam logic [VAL_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  localparam int HUE_W = 16;
  localparam logic [HUE_W-1:0] HUE_TURN   = 16'd23040;
  localparam logic [HUE_W-1:0] HUE_SECTOR = 16'd3840;

  localparam int REM_W = 12;
  localparam int SEC_W = 3;

  localparam logic [SEC_W-1:0] SEC_RED     = 3'd0;
  localparam logic [SEC_W-1:0] SEC_YELLOW  = 3'd1;
  localparam logic [SEC_W-1:0] SEC_GREEN   = 3'd2;
  localparam logic [SEC_W-1:0] SEC_CYAN    = 3'd3;
  localparam logic [SEC_W-1:0] SEC_BLUE    = 3'd4;
  localparam logic [SEC_W-1:0] SEC_MAGENTA = 3'd5;

  // sector width is 15 * 256, so f = (rem << (FRAC_BITS - 8)) / 15
  localparam int FRAC_SH = FRAC_BITS - 8;
  localparam int X_W     = REM_W + FRAC_SH;
  localparam int RCP_W   = FRAC_BITS + 1;
  localparam logic [RCP_W-1:0] RCP = RCP_W'((64'd1 << X_W) / 64'd15);
  localparam logic [3:0] DIV_BY = 4'd15;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [VAL_W-1:0] sat;
    logic [VAL_W-1:0] val;
  } pix_t;

  typedef struct packed {
    logic [SEC_W-1:0] sector;
    logic [REM_W-1:0] rem;
    logic [VAL_W-1:0] sat;
    logic [VAL_W-1:0] val;
    logic             grey;
  } sect_t;

  typedef struct packed {
    logic [SEC_W-1:0]     sector;
    logic [FRAC_BITS-1:0] f;
    logic [VAL_W-1:0]     sat;
    logic [VAL_W-1:0]     val;
    logic [VAL_W-1:0]     p;
    logic                 grey;
  } frac_t;

  typedef struct packed {
    logic [VAL_W-1:0] red;
    logic [VAL_W-1:0] green;
    logic [VAL_W-1:0] blue;
  } rgb_t;

endpackage

// ===== rtl/hsv_if.sv =====
// stream interfaces for hsv pixels in and rgb pixels out
interface hsv_pix_if;
  logic                           valid;
  logic                           ready;
  logic [hsv_pkg::HUE_W-1:0]      hue;
  logic [hsv_pkg::VAL_W-1:0]      saturation;
  logic [hsv_pkg::VAL_W-1:0]      brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

interface hsv_rgb_if;
  logic                      valid;
  logic                      ready;
  logic [hsv_pkg::VAL_W-1:0] red;
  logic [hsv_pkg::VAL_W-1:0] green;
  logic [hsv_pkg::VAL_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ===== rtl/hsv_to_rgb_converter_top.sv =====
// hsv to rgb converter: one pixel per cycle while out_rgb is ready, through a six-stage pipeline
// an accepted request is registered in the hsv_sector, hsv_frac and hsv_shade stages in turn before it reaches out_rgb
// throughput: one pixel per cycle, set by the stage-by-stage valid/ready chain
// a stalled output holds the pipeline; empty stages still fill, so in_pix waits only
// when every stage is full
// reset (rst_n low, synchronous) clears all stage valid bits; no other state
module hsv_to_rgb_converter_top (
  input  logic      clk,
  input  logic      rst_n,
  hsv_pix_if.sink   in_pix,
  hsv_rgb_if.source out_rgb
);

  hsv_pkg::pix_t  pix;
  hsv_pkg::sect_t sect;
  hsv_pkg::frac_t frac;
  hsv_pkg::rgb_t  rgb;
  logic           sect_valid;
  logic           sect_ready;
  logic           frac_valid;
  logic           frac_ready;

  assign pix.hue = in_pix.hue;
  assign pix.sat = in_pix.saturation;
  assign pix.val = in_pix.brightness;

  hsv_sector u_sector (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_pix.valid),
    .in_ready  (in_pix.ready),
    .in_data   (pix),
    .out_valid (sect_valid),
    .out_ready (sect_ready),
    .out_data  (sect)
  );

  hsv_frac u_frac (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sect_valid),
    .in_ready  (sect_ready),
    .in_data   (sect),
    .out_valid (frac_valid),
    .out_ready (frac_ready),
    .out_data  (frac)
  );

  hsv_shade u_shade (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (frac_valid),
    .in_ready  (frac_ready),
    .in_data   (frac),
    .out_valid (out_rgb.valid),
    .out_ready (out_rgb.ready),
    .out_data  (rgb)
  );

  assign out_rgb.red   = rgb.red;
  assign out_rgb.green = rgb.green;
  assign out_rgb.blue  = rgb.blue;

endmodule

// ===== rtl/hsv_sector.sv =====
// first stage: input clamp, hue wrap, sector and remainder within the sector
module hsv_sector (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  hsv_pkg::pix_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output hsv_pkg::sect_t out_data
);

  localparam logic [hsv_pkg::HUE_W-1:0] B1 = hsv_pkg::HUE_SECTOR;
  localparam logic [hsv_pkg::HUE_W-1:0] B2 = hsv_pkg::HUE_W'(hsv_pkg::HUE_SECTOR * 2);
  localparam logic [hsv_pkg::HUE_W-1:0] B3 = hsv_pkg::HUE_W'(hsv_pkg::HUE_SECTOR * 3);
  localparam logic [hsv_pkg::HUE_W-1:0] B4 = hsv_pkg::HUE_W'(hsv_pkg::HUE_SECTOR * 4);
  localparam logic [hsv_pkg::HUE_W-1:0] B5 = hsv_pkg::HUE_W'(hsv_pkg::HUE_SECTOR * 5);

  logic                          vld_r;
  logic                          en;
  hsv_pkg::sect_t                data_r;
  hsv_pkg::sect_t                data_nxt;
  logic [hsv_pkg::HUE_W-1:0]     hue_w;
  logic [hsv_pkg::HUE_W-1:0]     off;
  logic [hsv_pkg::HUE_W-1:0]     rem_full;
  logic [hsv_pkg::VAL_W-1:0]     sat_c;
  logic [hsv_pkg::VAL_W-1:0]     val_c;

  assign en        = !vld_r || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r;
  assign out_data  = data_r;

  always_comb begin
    sat_c = (in_data.sat > hsv_pkg::ONE) ? hsv_pkg::ONE : in_data.sat;
    val_c = (in_data.val > hsv_pkg::ONE) ? hsv_pkg::ONE : in_data.val;
    hue_w = (in_data.hue >= hsv_pkg::HUE_TURN) ? '0 : in_data.hue;
    priority if (hue_w >= B5) begin
      data_nxt.sector = hsv_pkg::SEC_MAGENTA;
      off = B5;
    end else if (hue_w >= B4) begin
      data_nxt.sector = hsv_pkg::SEC_BLUE;
      off = B4;
    end else if (hue_w >= B3) begin
      data_nxt.sector = hsv_pkg::SEC_CYAN;
      off = B3;
    end else if (hue_w >= B2) begin
      data_nxt.sector = hsv_pkg::SEC_GREEN;
      off = B2;
    end else if (hue_w >= B1) begin
      data_nxt.sector = hsv_pkg::SEC_YELLOW;
      off = B1;
    end else begin
      data_nxt.sector = hsv_pkg::SEC_RED;
      off = '0;
    end
    rem_full      = hue_w - off;
    data_nxt.rem  = rem_full[hsv_pkg::REM_W-1:0];
    data_nxt.sat  = sat_c;
    data_nxt.val  = val_c;
    data_nxt.grey = (sat_c == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== rtl/hsv_frac.sv =====
// two stages: reciprocal divide by 15 for the sector fraction, and the p term
module hsv_frac (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  hsv_pkg::sect_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output hsv_pkg::frac_t out_data
);

  localparam int PR_W = hsv_pkg::X_W + hsv_pkg::RCP_W;
  localparam int PV_W = 2 * hsv_pkg::VAL_W;

  // stage one registers
  logic                              vld1_r;
  logic [hsv_pkg::SEC_W-1:0]         sector1_r;
  logic [hsv_pkg::FRAC_BITS-1:0]     q0_r;
  logic [hsv_pkg::X_W-1:0]           x_r;
  logic [hsv_pkg::VAL_W-1:0]         sat1_r;
  logic [hsv_pkg::VAL_W-1:0]         val1_r;
  logic [hsv_pkg::VAL_W-1:0]         p1_r;
  logic                              grey1_r;
  // stage two registers
  logic                              vld2_r;
  hsv_pkg::frac_t                    data2_r;
  hsv_pkg::frac_t                    data2_nxt;

  logic                              en1;
  logic                              en2;
  logic [hsv_pkg::X_W-1:0]           x_nxt;
  logic [PR_W-1:0]                   prod;
  logic [PV_W-1:0]                   pprod;
  logic [hsv_pkg::X_W-1:0]           resid;

  assign en2       = !vld2_r || out_ready;
  assign en1       = !vld1_r || en2;
  assign in_ready  = en1;
  assign out_valid = vld2_r;
  assign out_data  = data2_r;

  always_comb begin
    x_nxt = hsv_pkg::X_W'(in_data.rem) << hsv_pkg::FRAC_SH;
    prod  = PR_W'(x_nxt) * PR_W'(hsv_pkg::RCP);
    pprod = PV_W'(in_data.val) * PV_W'(hsv_pkg::ONE - in_data.sat);
  end

  // quotient estimate is low by at most one
  always_comb begin
    resid = x_r - hsv_pkg::X_W'(q0_r) * hsv_pkg::X_W'(hsv_pkg::DIV_BY);
    data2_nxt.sector = sector1_r;
    data2_nxt.f      = (resid >= hsv_pkg::X_W'(hsv_pkg::DIV_BY)) ?
                       q0_r + hsv_pkg::FRAC_BITS'(1) : q0_r;
    data2_nxt.sat    = sat1_r;
    data2_nxt.val    = val1_r;
    data2_nxt.p      = p1_r;
    data2_nxt.grey   = grey1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      if (en1) begin
        vld1_r <= in_valid;
      end
      if (en2) begin
        vld2_r <= vld1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      sector1_r <= in_data.sector;
      q0_r      <= prod[hsv_pkg::X_W +: hsv_pkg::FRAC_BITS];
      x_r       <= x_nxt;
      sat1_r    <= in_data.sat;
      val1_r    <= in_data.val;
      p1_r      <= pprod[hsv_pkg::FRAC_BITS +: hsv_pkg::VAL_W];
      grey1_r   <= in_data.grey;
    end
    if (en2) begin
      data2_r <= data2_nxt;
    end
  end

endmodule

// ===== rtl/hsv_shade.sv =====
// three stages: s*f products, q and t products, sector mux into the output register
module hsv_shade (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  hsv_pkg::frac_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output hsv_pkg::rgb_t  out_data
);

  localparam int PV_W = 2 * hsv_pkg::VAL_W;

  logic                          vld1_r;
  logic                          vld2_r;
  logic                          vld3_r;
  logic                          en1;
  logic                          en2;
  logic                          en3;

  logic [hsv_pkg::SEC_W-1:0]     sector1_r;
  logic [hsv_pkg::VAL_W-1:0]     sf1_r;
  logic [hsv_pkg::VAL_W-1:0]     sft1_r;
  logic [hsv_pkg::VAL_W-1:0]     val1_r;
  logic [hsv_pkg::VAL_W-1:0]     p1_r;
  logic                          grey1_r;

  logic [hsv_pkg::SEC_W-1:0]     sector2_r;
  logic [hsv_pkg::VAL_W-1:0]     q2_r;
  logic [hsv_pkg::VAL_W-1:0]     t2_r;
  logic [hsv_pkg::VAL_W-1:0]     val2_r;
  logic [hsv_pkg::VAL_W-1:0]     p2_r;
  logic                          grey2_r;

  hsv_pkg::rgb_t                 rgb_r;
  hsv_pkg::rgb_t                 rgb_nxt;

  logic [PV_W-1:0]               sf_prod;
  logic [PV_W-1:0]               sft_prod;
  logic [PV_W-1:0]               q_prod;
  logic [PV_W-1:0]               t_prod;

  assign en3       = !vld3_r || out_ready;
  assign en2       = !vld2_r || en3;
  assign en1       = !vld1_r || en2;
  assign in_ready  = en1;
  assign out_valid = vld3_r;
  assign out_data  = rgb_r;

  always_comb begin
    sf_prod  = PV_W'(in_data.sat) * PV_W'(in_data.f);
    sft_prod = PV_W'(in_data.sat) * PV_W'(hsv_pkg::ONE - hsv_pkg::VAL_W'(in_data.f));
    q_prod   = PV_W'(val1_r) * PV_W'(hsv_pkg::ONE - sf1_r);
    t_prod   = PV_W'(val1_r) * PV_W'(hsv_pkg::ONE - sft1_r);
  end

  always_comb begin
    if (grey2_r) begin
      rgb_nxt = '{red: val2_r, green: val2_r, blue: val2_r};
    end else begin
      unique case (sector2_r)
        hsv_pkg::SEC_RED:    rgb_nxt = '{red: val2_r, green: t2_r,   blue: p2_r};
        hsv_pkg::SEC_YELLOW: rgb_nxt = '{red: q2_r,   green: val2_r, blue: p2_r};
        hsv_pkg::SEC_GREEN:  rgb_nxt = '{red: p2_r,   green: val2_r, blue: t2_r};
        hsv_pkg::SEC_CYAN:   rgb_nxt = '{red: p2_r,   green: q2_r,   blue: val2_r};
        hsv_pkg::SEC_BLUE:   rgb_nxt = '{red: t2_r,   green: p2_r,   blue: val2_r};
        default:             rgb_nxt = '{red: val2_r, green: p2_r,   blue: q2_r};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else begin
      if (en1) begin
        vld1_r <= in_valid;
      end
      if (en2) begin
        vld2_r <= vld1_r;
      end
      if (en3) begin
        vld3_r <= vld2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      sector1_r <= in_data.sector;
      sf1_r     <= sf_prod[hsv_pkg::FRAC_BITS +: hsv_pkg::VAL_W];
      sft1_r    <= sft_prod[hsv_pkg::FRAC_BITS +: hsv_pkg::VAL_W];
      val1_r    <= in_data.val;
      p1_r      <= in_data.p;
      grey1_r   <= in_data.grey;
    end
    if (en2) begin
      sector2_r <= sector1_r;
      q2_r      <= q_prod[hsv_pkg::FRAC_BITS +: hsv_pkg::VAL_W];
      t2_r      <= t_prod[hsv_pkg::FRAC_BITS +: hsv_pkg::VAL_W];
      val2_r    <= val1_r;
      p2_r      <= p1_r;
      grey2_r   <= grey1_r;
    end
    if (en3) begin
      rgb_r <= rgb_nxt;
    end
  end

endmodule

// ===== rtl/hsv_chk.sv =====
// port-level checker for the hsv to rgb converter and its bind
`include "hsv_to_rgb_converter_top_defines.svh"

module hsv_chk (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [hsv_pkg::VAL_W-1:0] out_red,
  input logic [hsv_pkg::VAL_W-1:0] out_green,
  input logic [hsv_pkg::VAL_W-1:0] out_blue
);

  // a free output stage means no stage can block
`HSV_ASSERT(a_ready_when_free, clk, rst_n, (!out_valid || out_ready) |-> in_ready, "input stalled with free output")

  // no result is left over from before reset
`HSV_ASSERT_ALWAYS(a_empty_after_reset, clk, $past(!rst_n) |-> !out_valid, "result valid after reset")

  // components never exceed one
`HSV_ASSERT(a_range, clk, rst_n, out_valid |-> (out_red <= hsv_pkg::ONE && out_green <= hsv_pkg::ONE && out_blue <= hsv_pkg::ONE), "component above one")

  // a stalled result holds
`HSV_ASSERT(a_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue)), "stalled result changed")

endmodule

bind hsv_to_rgb_converter_top hsv_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_pix.ready),
  .out_valid (out_rgb.valid),
  .out_ready (out_rgb.ready),
  .out_red   (out_rgb.red),
  .out_green (out_rgb.green),
  .out_blue  (out_rgb.blue)
);

// ===== dv/tb.sv =====
// self-checking testbench for the hsv to rgb converter: directed table, then random pixels
module tb;
  import hsv_pkg::*;

  localparam int RANDOM_PIXELS  = 550;
  localparam int DIRECTED_ROWS  = 21;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int STALL_CYCLES   = 64;
  localparam int STALL_AFTER    = 120;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [VAL_W-1:0] sat;
    logic [VAL_W-1:0] val;
    bit               typed;
    logic [VAL_W-1:0] red;
    logic [VAL_W-1:0] green;
    logic [VAL_W-1:0] blue;
  } pix_row_t;

  logic clk;
  logic rst_n;

  hsv_pix_if in_pix();
  hsv_rgb_if out_rgb();

  hsv_to_rgb_converter_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (in_pix),
    .out_rgb (out_rgb)
  );

  rgb_t     expected_rgb[$];
  pix_row_t directed_tbl[DIRECTED_ROWS];
  int       fail_cnt = 0;
  int       tx_idle_pct = 8;
  int       rx_idle_pct = 78;
  int       quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic rgb_t predict_rgb(logic [HUE_W-1:0] hue, logic [VAL_W-1:0] sat_in,
                                       logic [VAL_W-1:0] val_in);
    int unsigned      one_v, h, s, v, f, p, q, t, r, g, b;
    logic [SEC_W-1:0] sec;
    rgb_t             res;
    one_v = ONE;
    s = (sat_in > ONE) ? one_v : sat_in;
    v = (val_in > ONE) ? one_v : val_in;
    h = hue;
    if (s == 0) begin
      r = v;
      g = v;
      b = v;
    end else begin
      if (h >= HUE_TURN) h = 0;
      sec = SEC_W'(h / HUE_SECTOR);
      f = ((h % HUE_SECTOR) * one_v) / HUE_SECTOR;
      p = (v * (one_v - s)) >> FRAC_BITS;
      q = (v * (one_v - ((s * f) >> FRAC_BITS))) >> FRAC_BITS;
      t = (v * (one_v - ((s * (one_v - f)) >> FRAC_BITS))) >> FRAC_BITS;
      case (sec)
        SEC_RED:    {r, g, b} = {v, t, p};
        SEC_YELLOW: {r, g, b} = {q, v, p};
        SEC_GREEN:  {r, g, b} = {p, v, t};
        SEC_CYAN:   {r, g, b} = {p, q, v};
        SEC_BLUE:   {r, g, b} = {t, p, v};
        default:    {r, g, b} = {v, p, q};
      endcase
    end
    res.red   = VAL_W'(r);
    res.green = VAL_W'(g);
    res.blue  = VAL_W'(b);
    return res;
  endfunction

  function automatic logic [VAL_W-1:0] rand_frac();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return '0;
    if (pick < 18) return ONE;
    if (pick < 30) return VAL_W'($urandom_range(4097, 8191));
    return VAL_W'($urandom_range(1, 4095));
  endfunction

  task automatic send_pix(input pix_row_t row);
    rgb_t typed_rgb;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_pix.valid <= 1'b0;
      @(posedge clk);
    end
    in_pix.valid      <= 1'b1;
    in_pix.hue        <= row.hue;
    in_pix.saturation <= row.sat;
    in_pix.brightness <= row.val;
    do @(posedge clk); while (!in_pix.ready);
    typed_rgb.red   = row.red;
    typed_rgb.green = row.green;
    typed_rgb.blue  = row.blue;
    expected_rgb.push_back(row.typed ? typed_rgb : predict_rgb(row.hue, row.sat, row.val));
  endtask

  // request driver and end of run
  initial begin
    pix_row_t row;
    int       pick;
    rst_n             <= 1'b0;
    in_pix.valid      <= 1'b0;
    in_pix.hue        <= '0;
    in_pix.saturation <= '0;
    in_pix.brightness <= '0;
    directed_tbl = '{
      '{16'd0,     13'd0,    13'd0,    1'b1, 13'd0,    13'd0,    13'd0},
      '{16'd0,     13'd0,    13'd4096, 1'b1, 13'd4096, 13'd4096, 13'd4096},
      '{16'd5000,  13'd0,    13'd1234, 1'b1, 13'd1234, 13'd1234, 13'd1234},
      '{16'd40000, 13'd0,    13'd8191, 1'b1, 13'd4096, 13'd4096, 13'd4096},
      '{16'd0,     13'd4096, 13'd4096, 1'b1, 13'd4096, 13'd0,    13'd0},
      '{16'd3840,  13'd4096, 13'd4096, 1'b1, 13'd4096, 13'd4096, 13'd0},
      '{16'd7680,  13'd4096, 13'd4096, 1'b1, 13'd0,    13'd4096, 13'd0},
      '{16'd11520, 13'd4096, 13'd4096, 1'b1, 13'd0,    13'd4096, 13'd4096},
      '{16'd15360, 13'd4096, 13'd4096, 1'b1, 13'd0,    13'd0,    13'd4096},
      '{16'd19200, 13'd4096, 13'd4096, 1'b1, 13'd4096, 13'd0,    13'd4096},
      '{16'd23039, 13'd4096, 13'd4096, 1'b0, 13'd0,    13'd0,    13'd0},
      '{16'd23040, 13'd4096, 13'd4096, 1'b1, 13'd4096, 13'd0,    13'd0},
      '{16'd65535, 13'd4096, 13'd4096, 1'b1, 13'd4096, 13'd0,    13'd0},
      '{16'd0,     13'd8191, 13'd8191, 1'b1, 13'd4096, 13'd0,    13'd0},
      '{16'd65535, 13'd8191, 13'd8191, 1'b1, 13'd4096, 13'd0,    13'd0},
      '{16'd1234,  13'd8191, 13'd0,    1'b1, 13'd0,    13'd0,    13'd0},
      '{16'd0,     13'd4096, 13'd0,    1'b1, 13'd0,    13'd0,    13'd0},
      '{16'd1920,  13'd4097, 13'd2048, 1'b0, 13'd0,    13'd0,    13'd0},
      '{16'd10000, 13'd2048, 13'd8191, 1'b0, 13'd0,    13'd0,    13'd0},
      '{16'd12345, 13'd1,    13'd4096, 1'b0, 13'd0,    13'd0,    13'd0},
      '{16'd3839,  13'd4095, 13'd4095, 1'b0, 13'd0,    13'd0,    13'd0}
    };
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_tbl[i]) send_pix(directed_tbl[i]);
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if (i == RANDOM_PIXELS / 3) begin
        tx_idle_pct = 78;
        rx_idle_pct = 8;
      end
      if (i == 2 * RANDOM_PIXELS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 75) row.hue = HUE_W'($urandom_range(0, 23039));
      else if (pick < 80) row.hue = HUE_SECTOR * HUE_W'($urandom_range(0, 6));
      else row.hue = HUE_W'($urandom);
      row.sat   = rand_frac();
      row.val   = rand_frac();
      row.typed = 1'b0;
      row.red   = '0;
      row.green = '0;
      row.blue  = '0;
      send_pix(row);
    end
    in_pix.valid <= 1'b0;
    while (expected_rgb.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // result receiver with one long hold-off to back up the pipeline
  initial begin
    int stall_left;
    int rx_count;
    bit stall_done;
    stall_left = 0;
    rx_count   = 0;
    stall_done = 1'b0;
    out_rgb.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_rgb.valid && out_rgb.ready) rx_count++;
      if (!stall_done && rx_count >= STALL_AFTER) begin
        stall_left = STALL_CYCLES;
        stall_done = 1'b1;
      end
      if (stall_left > 0) begin
        out_rgb.ready <= 1'b0;
        stall_left--;
      end else begin
        out_rgb.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    rgb_t exp_rgb;
    if (rst_n && out_rgb.valid && out_rgb.ready) begin
      if (expected_rgb.size() == 0) begin
        $error("result with no request pending: red %0d green %0d blue %0d",
               out_rgb.red, out_rgb.green, out_rgb.blue);
        fail_cnt++;
      end else begin
        exp_rgb = expected_rgb.pop_front();
        if (out_rgb.red !== exp_rgb.red) begin
          $error("red: expected %0d, got %0d", exp_rgb.red, out_rgb.red);
          fail_cnt++;
        end
        if (out_rgb.green !== exp_rgb.green) begin
          $error("green: expected %0d, got %0d", exp_rgb.green, out_rgb.green);
          fail_cnt++;
        end
        if (out_rgb.blue !== exp_rgb.blue) begin
          $error("blue: expected %0d, got %0d", exp_rgb.blue, out_rgb.blue);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_pix.valid && in_pix.ready) || (out_rgb.valid && out_rgb.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
